// ===== src/ssfr_pkg.sv =====
// Package for the servo status frame receiver: constants, codes and shared types.
// Used by ssfr_frame_state and servo_status_frame_receiver_core; no dependencies.
`timescale 1ns / 1ps

package ssfr_pkg;

   // Frame geometry
   localparam int MAX_FRAME      = 32;   // bytes kept per frame, 11..63
   localparam int COUNT_W        = 6;    // byte counter width
   localparam int PAYLOAD_FIRST  = 4;    // frame index of the error byte
   localparam int PAYLOAD_DEPTH  = 7;    // error byte plus six payload bytes
   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [COUNT_W-1:0] MIN_FRAME = COUNT_W'(6);

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT0_ID    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOT1_ID    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_LEN = 2'd2;

   // Reset values of the configuration registers
   localparam logic [7:0] SLOT0_ID_RESET     = 8'd1;
   localparam logic [7:0] SLOT1_ID_RESET     = 8'd2;
   localparam logic [7:0] EXPECTED_LEN_RESET = 8'd8;

   localparam int RSP_DATA_W = 72;   // 68 payload bits padded to whole bytes

   typedef enum logic [2:0] {
      STATUS_STORED       = 3'd0,
      STATUS_TOO_SHORT    = 3'd1,
      STATUS_BAD_HEADER   = 3'd2,
      STATUS_BAD_CHECKSUM = 3'd3,
      STATUS_REJECTED     = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] slot0_id;
      logic [7:0] slot1_id;
      logic [7:0] expected_len;
   } cfg_type;

   typedef struct packed {
      status_type  frame_status;
      logic        servo_slot;
      logic [7:0]  node_id;
      logic [7:0]  fault_byte;
      logic [15:0] position;
      logic [15:0] speed;
      logic [15:0] load;
   } result_type;

endpackage

// ===== src/servo_status_frame_receiver_core.sv =====
// Servo status frame receiver, top level: stream ports, configuration
// registers, input and result registers. Depends on ssfr_pkg, ssfr_frame_state.
`timescale 1ns / 1ps

// Takes one received bus byte per request, with tlast on the last byte before
// the line goes idle, and one byte can be accepted every cycle while the
// receiver does not stall. A result passes from the input register through
// the frame check into the result register. Only bytes with tlast produce a
// result. The receiver stalls (req_tready low) only when the result register
// holds an untaken result and the input register is also full. Bytes past
// MAX_FRAME in a frame are dropped but tlast on them still closes the frame.
// Configuration is written through csr_* while no frame is in flight; indexes
// beyond the register list are ignored.
module servo_status_frame_receiver_core
   import ssfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] rx_byte
   input  logic                   req_tlast,   // frame_end
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [2:0] frame_status, [3] servo_slot, [11:4] node_id, [19:12] fault_byte,
   // [35:20] position, [51:36] speed, [67:52] load, [71:68] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       rsp_valid_ff;
   result_type rsp_data_ff;
   result_type result;
   logic       out_free;
   logic       step;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot0_id     <= SLOT0_ID_RESET;
         cfg_ff.slot1_id     <= SLOT1_ID_RESET;
         cfg_ff.expected_len <= EXPECTED_LEN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SLOT0_ID:     cfg_ff.slot0_id     <= csr_wdata;
            CSR_SLOT1_ID:     cfg_ff.slot1_id     <= csr_wdata;
            CSR_EXPECTED_LEN: cfg_ff.expected_len <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: the input register moves on whenever the result slot is free
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   ssfr_frame_state u_frame_state (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .step_byte  (in_byte_ff),
      .step_end   (in_end_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step && in_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step && in_end_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_data_ff.load,
                        rsp_data_ff.speed,
                        rsp_data_ff.position,
                        rsp_data_ff.fault_byte,
                        rsp_data_ff.node_id,
                        rsp_data_ff.servo_slot,
                        rsp_data_ff.frame_status};

endmodule

// ===== src/ssfr_frame_state.sv =====
// Per-frame state of the receiver: byte counter, checksum, captured fields and
// the frame verdict. Depends on ssfr_pkg.
`timescale 1ns / 1ps

module ssfr_frame_state
   import ssfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,   // one byte is processed this cycle
   input  logic [7:0] step_byte,
   input  logic       step_end,     // last byte of the frame
   input  cfg_type    cfg,
   output result_type result        // verdict for a step with step_end set
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]         running_sum_ff, running_sum_in;
   logic               header_ok_ff, header_ok_in;
   logic [7:0]         frame_id_ff, frame_id_in;
   logic [7:0]         frame_length_ff, frame_length_in;
   logic [7:0]         last_byte_ff, last_byte_in;
   logic [7:0]         payload_ff [PAYLOAD_DEPTH];
   logic [7:0]         payload_in [PAYLOAD_DEPTH];

   logic               keep;
   status_type         status;
   logic               slot;

   // Update with the new byte, as long as the frame has room for it
   always_comb begin
      keep            = byte_count_ff < COUNT_W'(MAX_FRAME);
      byte_count_in   = byte_count_ff;
      running_sum_in  = running_sum_ff;
      header_ok_in    = header_ok_ff;
      frame_id_in     = frame_id_ff;
      frame_length_in = frame_length_ff;
      last_byte_in    = last_byte_ff;
      for (int j = 0; j < PAYLOAD_DEPTH; j++) begin
         payload_in[j] = payload_ff[j];
      end
      if (keep) begin
         if (byte_count_ff < COUNT_W'(2) && step_byte != SYNC_BYTE) begin
            header_ok_in = 1'b0;
         end
         if (byte_count_ff == COUNT_W'(2)) begin
            frame_id_in = step_byte;
         end
         if (byte_count_ff == COUNT_W'(3)) begin
            frame_length_in = step_byte;
         end
         // sum runs one byte behind, so the checksum byte stays out of it
         if (byte_count_ff >= COUNT_W'(3)) begin
            running_sum_in = running_sum_ff + last_byte_ff;
         end
         for (int j = 0; j < PAYLOAD_DEPTH; j++) begin
            if (byte_count_ff == COUNT_W'(PAYLOAD_FIRST + j)) begin
               payload_in[j] = step_byte;
            end
         end
         last_byte_in  = step_byte;
         byte_count_in = byte_count_ff + COUNT_W'(1);
      end
   end

   // Frame verdict from the updated state
   always_comb begin
      slot = 1'b0;
      if (byte_count_in < MIN_FRAME) begin
         status = STATUS_TOO_SHORT;
      end else if (!header_ok_in) begin
         status = STATUS_BAD_HEADER;
      end else if (~running_sum_in != last_byte_in) begin
         status = STATUS_BAD_CHECKSUM;
      end else if (frame_length_in != cfg.expected_len) begin
         status = STATUS_REJECTED;
      end else if (frame_id_in == cfg.slot0_id) begin
         status = STATUS_STORED;
      end else if (frame_id_in == cfg.slot1_id) begin
         status = STATUS_STORED;
         slot   = 1'b1;
      end else begin
         status = STATUS_REJECTED;
      end

      result              = '0;
      result.frame_status = status;
      if (status == STATUS_STORED) begin
         result.servo_slot = slot;
         result.node_id    = frame_id_in;
         result.fault_byte = payload_in[0];
         result.position   = {payload_in[2], payload_in[1]};
         result.speed      = {payload_in[4], payload_in[3]};
         result.load       = {payload_in[6], payload_in[5]};
      end
   end

   // State registers; counters restart at each frame end
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff   <= '0;
         running_sum_ff  <= '0;
         header_ok_ff    <= 1'b1;
         frame_id_ff     <= '0;
         frame_length_ff <= '0;
         last_byte_ff    <= '0;
         for (int j = 0; j < PAYLOAD_DEPTH; j++) begin
            payload_ff[j] <= '0;
         end
      end else if (step_valid) begin
         frame_id_ff     <= frame_id_in;
         frame_length_ff <= frame_length_in;
         last_byte_ff    <= last_byte_in;
         for (int j = 0; j < PAYLOAD_DEPTH; j++) begin
            payload_ff[j] <= payload_in[j];
         end
         if (step_end) begin
            byte_count_ff  <= '0;
            running_sum_ff <= '0;
            header_ok_ff   <= 1'b1;
         end else begin
            byte_count_ff  <= byte_count_in;
            running_sum_ff <= running_sum_in;
            header_ok_ff   <= header_ok_in;
         end
      end
   end

endmodule

// ===== bench/testbench.sv =====
// Testbench for servo_status_frame_receiver_core: random status frames, noise and
// config changes, results checked against an in-bench frame predictor.
// Depends on ssfr_pkg and servo_status_frame_receiver_core.
`timescale 1ns / 1ps

module testbench;
   import ssfr_pkg::*;

   typedef logic [7:0] byte_queue_type[$];

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } bus_byte_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #6 clock = ~clock;

   // DUT ports; the inputs are known from time zero
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_SLOT0_ID;
   logic [7:0]             csr_wdata  = 8'h00;

   servo_status_frame_receiver_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Bytes waiting to be offered, and frame results still owed by the DUT
   bus_byte_type bus_bytes[$];
   result_type   expected_status_frames[$];
   int           bytes_queued   = 0;
   int           mismatch_count = 0;

   // Predictor state: register copy plus per-frame parse state
   cfg_type            cfg_model = '{SLOT0_ID_RESET, SLOT1_ID_RESET, EXPECTED_LEN_RESET};
   logic [COUNT_W-1:0] kept_count  = '0;
   logic [7:0]         frame_sum   = 8'h00;
   logic               header_good = 1'b1;
   logic [7:0]         frame_id    = 8'h00;
   logic [7:0]         frame_len   = 8'h00;
   logic [7:0]         prev_byte   = 8'h00;
   logic [7:0]         payload_store [PAYLOAD_DEPTH] = '{default: 8'h00};

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      if (mismatch_count < 40)
         $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h",
                  $time, what, got, want);
      mismatch_count++;
   endtask

   // Parse one accepted byte; on frame end, judge the frame and queue its result
   task automatic receive_byte(input logic [7:0] b, input logic last);
      result_type r;
      status_type st;
      logic       slot;
      if (kept_count < MAX_FRAME) begin
         if (kept_count < 2 && b != SYNC_BYTE) header_good = 1'b0;
         if (kept_count == 2) frame_id = b;
         if (kept_count == 3) frame_len = b;
         // sum covers index 2 up to the byte before the newest one
         if (kept_count >= 3) frame_sum = frame_sum + prev_byte;
         if (kept_count >= PAYLOAD_FIRST && kept_count < PAYLOAD_FIRST + PAYLOAD_DEPTH)
            payload_store[kept_count - PAYLOAD_FIRST] = b;
         prev_byte = b;
         kept_count++;
      end
      if (!last) return;
      slot = 1'b0;
      if (kept_count < MIN_FRAME)
         st = STATUS_TOO_SHORT;
      else if (!header_good)
         st = STATUS_BAD_HEADER;
      else if (8'(~frame_sum) != prev_byte)
         st = STATUS_BAD_CHECKSUM;
      else if (frame_len != cfg_model.expected_len)
         st = STATUS_REJECTED;
      else if (frame_id == cfg_model.slot0_id)
         st = STATUS_STORED;
      else if (frame_id == cfg_model.slot1_id) begin
         st = STATUS_STORED;
         slot = 1'b1;
      end else
         st = STATUS_REJECTED;
      r = '0;
      r.frame_status = st;
      if (st == STATUS_STORED) begin
         r.servo_slot = slot;
         r.node_id    = frame_id;
         r.fault_byte = payload_store[0];
         r.position   = {payload_store[2], payload_store[1]};
         r.speed      = {payload_store[4], payload_store[3]};
         r.load       = {payload_store[6], payload_store[5]};
      end
      expected_status_frames.push_back(r);
      kept_count  = '0;
      frame_sum   = 8'h00;
      header_good = 1'b1;
   endtask

   // Compare one taken result with the oldest owed one
   task automatic check_status_frame(input logic [RSP_DATA_W-1:0] d);
      result_type want;
      if (expected_status_frames.size() == 0) begin
         report_mismatch("result with no frame end outstanding", d[15:0], 16'h0);
         return;
      end
      want = expected_status_frames.pop_front();
      if (d[2:0] !== want.frame_status)
         report_mismatch("frame_status", 16'(d[2:0]), 16'(want.frame_status));
      if (d[3] !== want.servo_slot)
         report_mismatch("servo_slot", 16'(d[3]), 16'(want.servo_slot));
      if (d[11:4] !== want.node_id)
         report_mismatch("node_id", 16'(d[11:4]), 16'(want.node_id));
      if (d[19:12] !== want.fault_byte)
         report_mismatch("fault_byte", 16'(d[19:12]), 16'(want.fault_byte));
      if (d[35:20] !== want.position)
         report_mismatch("position", d[35:20], want.position);
      if (d[51:36] !== want.speed)
         report_mismatch("speed", d[51:36], want.speed);
      if (d[67:52] !== want.load)
         report_mismatch("load", d[67:52], want.load);
   endtask

   // Stimulus helpers
   task automatic push_byte(input logic [7:0] data, input logic last);
      bus_bytes.push_back('{data, last});
      bytes_queued++;
   endtask

   function automatic byte_queue_type random_bytes(input int n);
      byte_queue_type q;
      int k;
      for (k = 0; k < n; k++) q.push_back(8'($urandom));
      return q;
   endfunction

   // Header, id, length, data, checksum; overlong adds dropped tail bytes,
   // corrupt flips one random bit somewhere in the frame
   task automatic queue_status_frame(input logic [7:0] id, input logic [7:0] len,
                                     input byte_queue_type data, input bit overlong,
                                     input bit corrupt);
      byte_queue_type body;
      logic [7:0]     sum;
      int             k, pos, n_extra;
      body = '{SYNC_BYTE, SYNC_BYTE, id, len};
      sum  = id + len;
      for (k = 0; k < data.size(); k++) begin
         body.push_back(data[k]);
         sum = sum + data[k];
      end
      body.push_back(~sum);
      if (overlong) begin
         n_extra = $urandom_range(1, 8);
         for (k = 0; k < n_extra; k++) body.push_back(8'($urandom));
      end
      if (corrupt) begin
         pos = $urandom_range(0, body.size() - 1);
         body[pos] = body[pos] ^ 8'(1 << $urandom_range(0, 7));
      end
      for (k = 0; k < body.size(); k++) push_byte(body[k], k == body.size() - 1);
   endtask

   // Mostly well-formed frames aimed at the current slots, plus broken ones and noise
   task automatic queue_random_traffic(input int n_bytes);
      int         stop, pick, n, k;
      logic [7:0] id, len;
      stop = bytes_queued + n_bytes;
      while (bytes_queued < stop) begin
         pick = $urandom_range(0, 99);
         n    = $urandom_range(0, 9);
         id   = (n < 4) ? cfg_model.slot0_id :
                (n < 8) ? cfg_model.slot1_id : 8'($urandom);
         len  = ($urandom_range(0, 9) < 8) ? cfg_model.expected_len : 8'($urandom);
         if (pick < 60) begin
            n = $urandom_range(0, 9);
            if (n < 7)
               n = PAYLOAD_DEPTH;
            else if (n < 9)
               n = $urandom_range(1, PAYLOAD_DEPTH - 1);
            else
               n = $urandom_range(PAYLOAD_DEPTH + 1, 20);
            queue_status_frame(id, len, random_bytes(n), 1'b0, 1'b0);
         end else if (pick < 68)
            queue_status_frame(id, len, random_bytes(MAX_FRAME - 5), 1'b1, 1'b0);
         else if (pick < 78)
            queue_status_frame(id, len, random_bytes(PAYLOAD_DEPTH), 1'b0, 1'b1);
         else if (pick < 86) begin
            // too short: sync bytes then an early frame end
            n = $urandom_range(1, 5);
            for (k = 0; k < n; k++)
               push_byte((k < 2) ? SYNC_BYTE : 8'($urandom), k == n - 1);
         end else begin
            n = $urandom_range(1, 12);
            for (k = 0; k < n; k++)
               push_byte(8'($urandom), k == n - 1 || $urandom_range(0, 5) == 0);
         end
      end
   endtask

   task automatic set_config(input logic [7:0] s0, input logic [7:0] s1,
                             input logic [7:0] len);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_SLOT0_ID;
      csr_wdata <= s0;
      @(posedge clock);
      csr_index <= CSR_SLOT1_ID;
      csr_wdata <= s1;
      @(posedge clock);
      csr_index <= CSR_EXPECTED_LEN;
      csr_wdata <= len;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_model = '{s0, s1, len};
   endtask

   // All bytes taken, all results back, then room for a frame still in flight
   task automatic wait_idle();
      while (bus_bytes.size() != 0 || req_tvalid || expected_status_frames.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Request driver: bursts of random length with random gaps
   int           burst_left = 0;
   int           gap_left   = 0;
   bus_byte_type next_byte;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) receive_byte(req_tdata, req_tlast);
         if (req_tvalid && !req_tready) begin
            // request still pending: hold it
         end else if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (bus_bytes.size() != 0) begin
            next_byte = bus_bytes.pop_front();
            req_tdata  <= next_byte.data;
            req_tlast  <= next_byte.last;
            req_tvalid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                        : $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else
               burst_left--;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result monitor: checks taken results, stalls in modes, with long holds
   int   cycle_count = 0;
   int   hold_left   = 0;
   int   ready_mode  = 0;
   int   mode_left   = 0;
   logic ready_next;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_status_frame(rsp_tdata);
         cycle_count++;
         // long hold-off so the DUT backs up into req_tready
         if (hold_left == 0 && (cycle_count % 2500 == 400 || $urandom_range(0, 999) == 0))
            hold_left = $urandom_range(40, 90);
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(10, 120);
         end else
            mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (ready_mode)
               2:       ready_next = 1'($urandom_range(0, 1));
               3:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = 1'b1;
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Test sequence
   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // good frame with extreme payload values for slot 0
      queue_status_frame(SLOT0_ID_RESET, EXPECTED_LEN_RESET,
                         '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80, 8'h7F}, 1'b0, 1'b0);
      // frame end on the very first byte
      push_byte(SYNC_BYTE, 1'b1);
      // first sync byte wrong
      push_byte(8'h00, 1'b0);
      push_byte(SYNC_BYTE, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h08, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hF6, 1'b1);
      // shortest valid frame for slot 1: stale payload, checksum lands in position
      queue_status_frame(SLOT1_ID_RESET, EXPECTED_LEN_RESET, '{8'h55}, 1'b0, 1'b0);
      queue_random_traffic(300);
      wait_idle();

      set_config(8'h00, 8'hFF, 8'h00);
      queue_random_traffic(250);
      wait_idle();

      // both slots equal: slot 0 takes the frame
      set_config(8'hFF, 8'hFF, 8'hFF);
      queue_random_traffic(250);
      wait_idle();

      set_config(8'($urandom), 8'($urandom), 8'($urandom_range(0, 255)));
      queue_random_traffic(350);
      wait_idle();

      repeat (8) @(negedge clock);
      if (mismatch_count == 0 && expected_status_frames.size() == 0)
         $display("servo_status_frame_receiver_core verification clean");
      else
         $display("servo_status_frame_receiver_core verification failed");
      $finish;
   end

   // Watchdog
   initial begin
      #5000000;
      $display("servo_status_frame_receiver_core verification failed");
      $finish;
   end

endmodule
